/* hdl/prt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and constants of the pending command retry table.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int SLOTS       = 8;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int MAC_W        = 48;
    localparam int TIME_W       = 32;
    localparam int ATT_W        = 8;
    localparam int SLOT_FIELD_W = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [SLOT_W-1:0] IDX_FIRST = '0;
    localparam logic [SLOT_W-1:0] IDX_STEP  = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] LAST_IDX  = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(MAX_RESULTS);
    localparam logic [ATT_W-1:0]  ATT_ONE   = ATT_W'(1);

    localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd500;
    localparam logic [ATT_W-1:0]  MAX_ATT_RST  = 8'd30;
    localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd10000;

    typedef enum logic [1:0] {
        MODE_SUBMIT   = 2'd0,
        MODE_ACK      = 2'd1,
        MODE_RESPONSE = 2'd2,
        MODE_TICK     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        EV_SEND          = 3'd0,
        EV_RESEND        = 3'd1,
        EV_NOT_CONNECTED = 3'd2,
        EV_IN_FLIGHT     = 3'd3,
        EV_FULL          = 3'd4,
        EV_TIMEOUT       = 3'd5,
        EV_COMPLETED     = 3'd6
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_MAX_ATT  = 2'd1,
        CFG_TIMEOUT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUBMIT_END,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        event_t                  ev;
        logic [SLOT_FIELD_W-1:0] slot_no;
        logic [MAC_W-1:0]        mac;
        logic [ATT_W-1:0]        att;
        logic                    pending;
        logic                    last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic submit_end;
        logic flush;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic stop;
        logic last_idx;
        logic is_submit;
        logic hold_valid;
    } dp_status_t;

endpackage

/* hdl/prt_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_cmd_if / prt_evt_if
// Valid/ready channels for input items and result events.
// ----------------------------------------------------------------------------
interface prt_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [prt_pkg::MAC_W-1:0]   device_mac;
    logic                        device_known;
    logic [prt_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, mode, device_mac, device_known, now_ms, input ready);
    modport sink (input valid, mode, device_mac, device_known, now_ms, output ready);
endinterface

interface prt_evt_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        event_res;
    logic [prt_pkg::SLOT_FIELD_W-1:0]  slot;
    logic [prt_pkg::MAC_W-1:0]         peer_mac;
    logic [prt_pkg::ATT_W-1:0]         attempt_count;
    logic                              any_pending;
    logic                              last;

    modport source (output valid, event_res, slot, peer_mac, attempt_count, any_pending, last,
                    input ready);
    modport sink (input valid, event_res, slot, peer_mac, attempt_count, any_pending, last,
                  output ready);
endinterface

/* hdl/prt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_datapath
// Slot table, configuration registers, per-slot evaluation and the
// hold and output registers of the result events.
// ----------------------------------------------------------------------------
module prt_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  prt_pkg::ctl_cmd_t                   ctl,
    output prt_pkg::dp_status_t                 sts,
    input  logic [1:0]                          mode,
    input  logic [prt_pkg::MAC_W-1:0]           device_mac,
    input  logic                                device_known,
    input  logic [prt_pkg::TIME_W-1:0]          now_ms,
    input  logic                                cfg_we,
    input  logic [prt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [prt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                evt_ready,
    output logic                                evt_valid,
    output prt_pkg::result_t                    evt_res
);

    // Configuration
    logic [prt_pkg::TIME_W-1:0] interval_reg;
    logic [prt_pkg::ATT_W-1:0]  max_att_reg;
    logic [prt_pkg::TIME_W-1:0] timeout_reg;

    // Captured item
    prt_pkg::mode_t             mode_reg;
    logic [prt_pkg::MAC_W-1:0]  mac_reg;
    logic                       known_reg;
    logic [prt_pkg::TIME_W-1:0] now_reg;

    // Scan state
    logic [prt_pkg::SLOT_W-1:0] idx_reg;
    logic                       dup_reg;
    logic                       free_found_reg;
    logic [prt_pkg::SLOT_W-1:0] free_idx_reg;
    logic [prt_pkg::CNT_W-1:0]  res_cnt_reg;

    // Slot table
    logic [prt_pkg::SLOTS-1:0]  used_reg;
    logic [prt_pkg::SLOTS-1:0]  acked_reg;
    logic [prt_pkg::MAC_W-1:0]  peer_mem [prt_pkg::SLOTS];
    logic [prt_pkg::ATT_W-1:0]  att_mem  [prt_pkg::SLOTS];
    logic [prt_pkg::TIME_W-1:0] sent_mem [prt_pkg::SLOTS];
    logic [prt_pkg::TIME_W-1:0] ack_mem  [prt_pkg::SLOTS];

    // Result registers
    logic                       hold_valid_reg;
    prt_pkg::result_t           hold_res_reg;
    logic                       out_valid_reg;
    prt_pkg::result_t           out_res_reg;
    prt_pkg::result_t           out_res_next;

    // Evaluation of the slot under the scan index
    logic                       cur_used;
    logic                       cur_acked;
    logic [prt_pkg::MAC_W-1:0]  cur_peer;
    logic [prt_pkg::ATT_W-1:0]  cur_att;
    logic [prt_pkg::TIME_W-1:0] elapsed;
    logic [prt_pkg::TIME_W-1:0] limit;
    logic                       due;
    logic                       peer_hit;
    logic [prt_pkg::ATT_W-1:0]  att_inc;
    logic [prt_pkg::SLOTS-1:0]  used_wo_cur;
    logic [31:0]                idx_wide;
    logic [31:0]                free_wide;

    logic                       step_stop;
    logic                       step_res_valid;
    logic                       step_clear;
    logic                       step_ack;
    logic                       step_resend;
    prt_pkg::result_t           step_res;
    logic                       end_alloc;
    prt_pkg::result_t           end_res;

    logic                       new_valid;
    prt_pkg::result_t           new_res;
    logic                       emit;
    logic                       load_out;
    logic [prt_pkg::SLOT_W-1:0] wr_idx;

    assign idx_wide  = 32'(idx_reg);
    assign free_wide = 32'(free_idx_reg);

    always_comb
    begin
        cur_used  = used_reg[idx_reg];
        cur_acked = acked_reg[idx_reg];
        cur_peer  = peer_mem[idx_reg];
        cur_att   = att_mem[idx_reg];
        peer_hit  = cur_used && (cur_peer == mac_reg);
        // Acked slots race the response deadline, unacked ones the resend interval.
        elapsed   = now_reg - (cur_acked ? ack_mem[idx_reg] : sent_mem[idx_reg]);
        limit     = cur_acked ? timeout_reg : interval_reg;
        due       = (elapsed >= limit);
        att_inc   = cur_att + prt_pkg::ATT_ONE;
        used_wo_cur = used_reg;
        used_wo_cur[idx_reg] = 1'b0;

        step_stop      = 1'b0;
        step_res_valid = 1'b0;
        step_clear     = 1'b0;
        step_ack       = 1'b0;
        step_resend    = 1'b0;
        step_res.ev      = prt_pkg::EV_TIMEOUT;
        step_res.slot_no = idx_wide[prt_pkg::SLOT_FIELD_W-1:0];
        step_res.mac     = cur_peer;
        step_res.att     = cur_att;
        step_res.pending = |used_wo_cur;
        step_res.last    = 1'b0;

        unique case (mode_reg)
            prt_pkg::MODE_SUBMIT:
            begin
                step_stop = 1'b0;
            end
            prt_pkg::MODE_ACK:
            begin
                if (peer_hit && !cur_acked)
                begin
                    step_ack  = 1'b1;
                    step_stop = 1'b1;
                end
            end
            prt_pkg::MODE_RESPONSE:
            begin
                if (peer_hit)
                begin
                    step_clear     = 1'b1;
                    step_stop      = 1'b1;
                    step_res_valid = 1'b1;
                    step_res.ev    = prt_pkg::EV_COMPLETED;
                end
            end
            prt_pkg::MODE_TICK:
            begin
                if (cur_used)
                begin
                    priority if (cur_acked)
                    begin
                        if (due)
                        begin
                            step_clear     = 1'b1;
                            step_res_valid = 1'b1;
                        end
                    end
                    else if (cur_att >= max_att_reg)
                    begin
                        step_clear     = 1'b1;
                        step_res_valid = 1'b1;
                    end
                    else if (due)
                    begin
                        step_resend      = 1'b1;
                        step_res_valid   = 1'b1;
                        step_res.ev      = prt_pkg::EV_RESEND;
                        step_res.att     = att_inc;
                        step_res.pending = 1'b1;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        end_alloc       = 1'b0;
        end_res.slot_no = '0;
        end_res.mac     = mac_reg;
        end_res.att     = '0;
        end_res.pending = |used_reg;
        end_res.last    = 1'b0;
        priority if (!known_reg)
        begin
            end_res.ev = prt_pkg::EV_NOT_CONNECTED;
        end
        else if (dup_reg)
        begin
            end_res.ev = prt_pkg::EV_IN_FLIGHT;
        end
        else if (!free_found_reg)
        begin
            end_res.ev = prt_pkg::EV_FULL;
        end
        else
        begin
            end_alloc       = 1'b1;
            end_res.ev      = prt_pkg::EV_SEND;
            end_res.slot_no = free_wide[prt_pkg::SLOT_FIELD_W-1:0];
            end_res.att     = prt_pkg::ATT_ONE;
            end_res.pending = 1'b1;
        end
    end

    // A new result first lands in the hold register; the one it displaces is
    // known not to be the last and moves on to the output register.
    assign new_valid = (ctl.step && step_res_valid) || ctl.submit_end;
    assign new_res   = ctl.submit_end ? end_res : step_res;
    assign emit      = new_valid && (res_cnt_reg < prt_pkg::CNT_LIMIT);
    assign load_out  = (emit && hold_valid_reg) || (ctl.flush && hold_valid_reg);
    assign wr_idx    = ctl.submit_end ? free_idx_reg : idx_reg;

    always_comb
    begin
        out_res_next      = hold_res_reg;
        out_res_next.last = ctl.flush;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= prt_pkg::INTERVAL_RST;
            max_att_reg    <= prt_pkg::MAX_ATT_RST;
            timeout_reg    <= prt_pkg::TIMEOUT_RST;
            idx_reg        <= prt_pkg::IDX_FIRST;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            res_cnt_reg    <= '0;
            used_reg       <= '0;
            acked_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (prt_pkg::cfg_idx_t'(cfg_index))
                    prt_pkg::CFG_INTERVAL: interval_reg <= cfg_data;
                    prt_pkg::CFG_MAX_ATT:  max_att_reg  <= cfg_data[prt_pkg::ATT_W-1:0];
                    prt_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                    default:               interval_reg <= interval_reg;
                endcase
            end

            if (ctl.load)
            begin
                idx_reg        <= prt_pkg::IDX_FIRST;
                dup_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                res_cnt_reg    <= '0;
            end

            if (ctl.step)
            begin
                idx_reg <= idx_reg + prt_pkg::IDX_STEP;
                if (mode_reg == prt_pkg::MODE_SUBMIT)
                begin
                    dup_reg <= dup_reg | peer_hit;
                    if (!free_found_reg && !cur_used)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
                if (step_clear)
                begin
                    used_reg[idx_reg]  <= 1'b0;
                    acked_reg[idx_reg] <= 1'b0;
                end
                if (step_ack)
                begin
                    acked_reg[idx_reg] <= 1'b1;
                end
            end

            if (ctl.submit_end && end_alloc)
            begin
                used_reg[free_idx_reg]  <= 1'b1;
                acked_reg[free_idx_reg] <= 1'b0;
            end

            if (emit)
            begin
                res_cnt_reg    <= res_cnt_reg + prt_pkg::CNT_ONE;
                hold_valid_reg <= 1'b1;
            end
            else if (ctl.flush)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mode_reg  <= prt_pkg::mode_t'(mode);
            mac_reg   <= device_mac;
            known_reg <= device_known;
            now_reg   <= now_ms;
        end
        if (ctl.step && (mode_reg == prt_pkg::MODE_SUBMIT) && !free_found_reg && !cur_used)
        begin
            free_idx_reg <= idx_reg;
        end
        if (emit)
        begin
            hold_res_reg <= new_res;
        end
        if (load_out)
        begin
            out_res_reg <= out_res_next;
        end
    end

    // Slot payload store, one write address per cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.submit_end && end_alloc)
        begin
            peer_mem[wr_idx] <= mac_reg;
            att_mem[wr_idx]  <= prt_pkg::ATT_ONE;
            sent_mem[wr_idx] <= now_reg;
        end
        if (ctl.step && step_resend)
        begin
            att_mem[wr_idx]  <= att_inc;
            sent_mem[wr_idx] <= now_reg;
        end
        if (ctl.step && step_ack)
        begin
            ack_mem[wr_idx] <= now_reg;
        end
    end

    assign sts.out_free   = !out_valid_reg || evt_ready;
    assign sts.stop       = step_stop;
    assign sts.last_idx   = (idx_reg == prt_pkg::LAST_IDX);
    assign sts.is_submit  = (mode_reg == prt_pkg::MODE_SUBMIT);
    assign sts.hold_valid = hold_valid_reg;

    assign evt_valid = out_valid_reg;
    assign evt_res   = out_res_reg;

endmodule

/* hdl/prt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_ctrl
// Sequencer: accepts an item, walks the slots, closes a submit and
// releases the final result of the item.
// ----------------------------------------------------------------------------
module prt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output prt_pkg::ctl_cmd_t    ctl,
    input  prt_pkg::dp_status_t  sts
);

    prt_pkg::state_t state_reg;
    prt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        ctl.load       = 1'b0;
        ctl.step       = 1'b0;
        ctl.submit_end = 1'b0;
        ctl.flush      = 1'b0;

        unique case (state_reg)
            prt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = prt_pkg::ST_SCAN;
                end
            end
            prt_pkg::ST_SCAN:
            begin
                // Every step may displace a held result, so it waits for room.
                if (sts.out_free)
                begin
                    ctl.step = 1'b1;
                    if (sts.stop || sts.last_idx)
                    begin
                        state_next = sts.is_submit ? prt_pkg::ST_SUBMIT_END
                                                   : prt_pkg::ST_FLUSH;
                    end
                end
            end
            prt_pkg::ST_SUBMIT_END:
            begin
                if (sts.out_free)
                begin
                    ctl.submit_end = 1'b1;
                    state_next     = prt_pkg::ST_FLUSH;
                end
            end
            prt_pkg::ST_FLUSH:
            begin
                if (!sts.hold_valid)
                begin
                    state_next = prt_pkg::ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    ctl.flush  = 1'b1;
                    state_next = prt_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

/* hdl/pending_command_retry_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_command_retry_table
// Per-peer stop-and-wait retry table for in-flight commands.
// ----------------------------------------------------------------------------
// One item is handled at a time and the slot table is walked one slot per
// clock, while the event output has room, through a single compare and
// elapsed-time unit. A tick or a submit walks every slot (a submit then adds
// its closing step), an ack or a response stops at the matching slot; a
// stalled event output adds its wait. Results pass through a hold register so
// that the final one of an item can carry its last mark; the next item is
// taken while that final event still waits to be read.
module pending_command_retry_table (
    input  logic                               clk,
    input  logic                               rst_n,
    prt_cmd_if.sink                            cmd,
    prt_evt_if.source                          evt,
    input  logic                               cfg_we,
    input  logic [prt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    prt_pkg::ctl_cmd_t   ctl;
    prt_pkg::dp_status_t sts;
    prt_pkg::result_t    evt_res;
    logic                evt_valid;
    logic                in_ready;

    prt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .ctl      (ctl),
        .sts      (sts)
    );

    prt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .mode         (cmd.mode),
        .device_mac   (cmd.device_mac),
        .device_known (cmd.device_known),
        .now_ms       (cmd.now_ms),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .evt_ready    (evt.ready),
        .evt_valid    (evt_valid),
        .evt_res      (evt_res)
    );

    assign cmd.ready         = in_ready;
    assign evt.valid         = evt_valid;
    assign evt.event_res     = evt_res.ev;
    assign evt.slot          = evt_res.slot_no;
    assign evt.peer_mac      = evt_res.mac;
    assign evt.attempt_count = evt_res.att;
    assign evt.any_pending   = evt_res.pending;
    assign evt.last          = evt_res.last;

    // An accepted transaction keeps the input closed for at least the scan.
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("input accepted twice in a row");

    // Rejections name no slot and report no attempts.
    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && (evt.event_res == prt_pkg::EV_NOT_CONNECTED ||
                      evt.event_res == prt_pkg::EV_IN_FLIGHT ||
                      evt.event_res == prt_pkg::EV_FULL)
        |-> evt.slot == '0 && evt.attempt_count == '0)
        else $error("rejection carries slot or attempt data");

    // A first send leaves its slot occupied with one attempt.
    a_send_fields: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && evt.event_res == prt_pkg::EV_SEND
        |-> evt.attempt_count == prt_pkg::ATT_ONE && evt.any_pending)
        else $error("send event with wrong attempt count or pending flag");

    // A resend follows at least one earlier attempt.
    a_resend_count: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && evt.event_res == prt_pkg::EV_RESEND
        |-> evt.attempt_count > prt_pkg::ATT_ONE && evt.any_pending)
        else $error("resend event with too few attempts");

endmodule
